// ----- hw/rtl/sidta_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg
// Shared constants and types for the signed integer to decimal text core.
// ----------------------------------------------------------------------------
package sidta_pkg;

  // input word and magnitude width
  localparam int ValueWidth   = 32;
  // decimal digits of the largest magnitude, 2147483648
  localparam int NumDigits    = 10;
  localparam int BcdWidth     = 4 * NumDigits;
  localparam int DigitCntW    = 4;
  // binary bits folded into the bcd word per pipeline stage
  localparam int BitsPerStage = 8;
  localparam int NumDabble    = ValueWidth / BitsPerStage;

  localparam int CharWidth = 8;
  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharNine  = 8'd57;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  // converted number handed from the pipeline to the character serializer
  typedef struct packed {
    logic                 neg;   // value was negative
    logic [DigitCntW-1:0] ndig;  // significant digits, 1..10
    logic [BcdWidth-1:0]  bcd;   // digits, most significant in the top nibble
  } conv_t;

endpackage

// ----- hw/rtl/sidta_conv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_conv
// Pipelined conversion of a signed 32-bit word into sign, digit count and
// left-aligned bcd digits. Stages: magnitude, four shift-add-3 stages of
// eight bits each, digit count and alignment. Every stage holds on a stall.
// ----------------------------------------------------------------------------
module sidta_conv (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sidta_pkg::ValueWidth-1:0]     in_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output sidta_pkg::conv_t                     out_o
);

  localparam int VW = sidta_pkg::ValueWidth;
  localparam int BW = sidta_pkg::BcdWidth;
  localparam int ND = sidta_pkg::NumDabble;

  // fold BitsPerStage binary bits into the bcd word
  function automatic logic [BW+VW-1:0] dabble(input logic [BW+VW-1:0] word);
    logic [BW+VW-1:0] w;
    w = word;
    for (int s = 0; s < sidta_pkg::BitsPerStage; s++) begin
      for (int n = 0; n < sidta_pkg::NumDigits; n++) begin
        if (w[VW + 4*n +: 4] >= 4'd5) begin
          w[VW + 4*n +: 4] = w[VW + 4*n +: 4] + 4'd3;
        end
      end
      w = w << 1;
    end
    return w;
  endfunction

  // stage 0: sign and magnitude
  logic          s0_valid_q;
  logic          s0_neg_q;
  logic [VW-1:0] s0_mag_q;
  logic          s0_ready;

  // shift-add-3 stages
  logic [ND-1:0] dv_q;
  logic [ND-1:0] dneg_q;
  logic [BW-1:0] dbcd_q [ND];
  logic [VW-1:0] dbin_q [ND];
  logic [ND-1:0] d_ready;

  // final stage: digit count and alignment
  logic             f_valid_q;
  sidta_pkg::conv_t f_q;
  sidta_pkg::conv_t f_d;
  logic             f_ready;

  // ready chain from the output back to the input
  always_comb begin
    f_ready = !f_valid_q || out_ready_i;
    d_ready[ND-1] = !dv_q[ND-1] || f_ready;
    for (int k = ND - 2; k >= 0; k--) begin
      d_ready[k] = !dv_q[k] || d_ready[k+1];
    end
    s0_ready = !s0_valid_q || d_ready[0];
  end

  assign in_ready_o = s0_ready;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      dv_q       <= '0;
      f_valid_q  <= 1'b0;
    end else begin
      if (s0_ready) begin
        s0_valid_q <= in_valid_i;
      end
      if (d_ready[0]) begin
        dv_q[0] <= s0_valid_q;
      end
      for (int k = 1; k < ND; k++) begin
        if (d_ready[k]) begin
          dv_q[k] <= dv_q[k-1];
        end
      end
      if (f_ready) begin
        f_valid_q <= dv_q[ND-1];
      end
    end
  end

  // magnitude of the two's complement word, most negative value included
  always_ff @(posedge clk_i) begin
    if (s0_ready && in_valid_i) begin
      s0_neg_q <= in_value_i[VW-1];
      s0_mag_q <= in_value_i[VW-1] ? (~in_value_i + VW'(1)) : in_value_i;
    end
  end

  // shift-add-3 payload
  always_ff @(posedge clk_i) begin
    if (d_ready[0] && s0_valid_q) begin
      dneg_q[0] <= s0_neg_q;
      {dbcd_q[0], dbin_q[0]} <= dabble({{BW{1'b0}}, s0_mag_q});
    end
    for (int k = 1; k < ND; k++) begin
      if (d_ready[k] && dv_q[k-1]) begin
        dneg_q[k] <= dneg_q[k-1];
        {dbcd_q[k], dbin_q[k]} <= dabble({dbcd_q[k-1], dbin_q[k-1]});
      end
    end
  end

  // count significant digits and move the leading digit to the top nibble
  always_comb begin
    logic [sidta_pkg::DigitCntW-1:0] n;
    logic [sidta_pkg::DigitCntW-1:0] pad;
    logic [5:0]                      sh;
    n = sidta_pkg::DigitCntW'(1);
    for (int i = 0; i < sidta_pkg::NumDigits; i++) begin
      if (dbcd_q[ND-1][4*i +: 4] != 4'd0) begin
        n = sidta_pkg::DigitCntW'(i + 1);
      end
    end
    pad = sidta_pkg::DigitCntW'(sidta_pkg::NumDigits) - n;
    sh  = {pad, 2'b00};
    f_d.neg  = dneg_q[ND-1];
    f_d.ndig = n;
    f_d.bcd  = dbcd_q[ND-1] << sh;
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && dv_q[ND-1]) begin
      f_q <= f_d;
    end
  end

  assign out_valid_o = f_valid_q;
  assign out_o       = f_q;

endmodule

// ----- hw/rtl/signed_int_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ascii text, one character per beat.
// ----------------------------------------------------------------------------
// Each input beat carries one signed 32-bit value; the core answers with its
// decimal text, most significant character first: a '-' for negative values,
// then the digits without leading zeros ("0" for zero, "-2147483648" for the
// most negative value). tlast marks the final character. The conversion is a
// six-stage pipeline that takes a value every cycle unless the serializer
// stalls it; the character port sends one character per cycle while tready is
// high, so a value makes 1 to 11 characters (digit count plus one for a minus
// sign). After the pipeline stages, the first character is registered in the serializer.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] ascii_char
  output logic        m_axis_tlast_o    // is_last
);

  localparam int BW = sidta_pkg::BcdWidth;
  localparam int CW = sidta_pkg::CharWidth;
  localparam int DW = sidta_pkg::DigitCntW;

  logic             cv_valid;
  logic             cv_ready;
  sidta_pkg::conv_t cv_data;

  // conversion pipeline
  sidta_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i),
    .out_valid_o (cv_valid),
    .out_ready_i (cv_ready),
    .out_o       (cv_data)
  );

  // character serializer with registered output
  logic          out_valid_q, out_valid_d;
  logic [CW-1:0] out_char_q,  out_char_d;
  logic          out_last_q,  out_last_d;
  logic [BW-1:0] rem_bcd_q,   rem_bcd_d;
  logic [DW-1:0] rem_cnt_q,   rem_cnt_d;

  // a new number loads when nothing is shown or its last beat leaves
  assign cv_ready = !out_valid_q || (m_axis_tready_i && out_last_q);

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    rem_bcd_d   = rem_bcd_q;
    rem_cnt_d   = rem_cnt_q;
    if (cv_ready) begin
      out_valid_d = cv_valid;
      if (cv_valid) begin
        if (cv_data.neg) begin
          out_char_d = sidta_pkg::CharMinus;
          out_last_d = 1'b0;
          rem_bcd_d  = cv_data.bcd;
          rem_cnt_d  = cv_data.ndig;
        end else begin
          out_char_d = sidta_pkg::CharZero + {4'd0, cv_data.bcd[BW-1 -: 4]};
          out_last_d = (cv_data.ndig == DW'(1));
          rem_bcd_d  = cv_data.bcd << 4;
          rem_cnt_d  = cv_data.ndig - DW'(1);
        end
      end
    end else if (m_axis_tready_i) begin
      // next digit of the current number
      out_char_d = sidta_pkg::CharZero + {4'd0, rem_bcd_q[BW-1 -: 4]};
      out_last_d = (rem_cnt_q == DW'(1));
      rem_bcd_d  = rem_bcd_q << 4;
      rem_cnt_d  = rem_cnt_q - DW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      rem_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
      rem_cnt_q   <= rem_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    rem_bcd_q  <= rem_bcd_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_char_q;
  assign m_axis_tlast_o  = out_last_q;

`ifndef SYNTHESIS
  // a beat that is not last always has digits left behind it
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> rem_cnt_q != '0)
    else $error("non-last beat with no digits remaining");

  // never more digits pending than a 32-bit value has
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_cnt_q <= DW'(sidta_pkg::NumDigits))
    else $error("remaining digit count out of range");

  // every character is a minus sign or a decimal digit
  a_char_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_char_q == sidta_pkg::CharMinus) ||
                    ((out_char_q >= sidta_pkg::CharZero) &&
                     (out_char_q <= sidta_pkg::CharNine)))
    else $error("character outside the decimal set");

  // a minus sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_char_q == sidta_pkg::CharMinus) |-> !out_last_q)
    else $error("minus sign marked as last character");

  // the beat after a minus sign that was taken is a digit
  a_digit_after_minus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && m_axis_tready_i && (out_char_q == sidta_pkg::CharMinus)
    |=> out_valid_q && (out_char_q != sidta_pkg::CharMinus))
    else $error("minus sign not followed by a digit");
`endif

endmodule
